// File: rtl/pbs_pkg.sv
// ----------------------------------------------------------------------------
// pbs_pkg
// Shared types and constants for the per-beat pressure statistics block.
// ----------------------------------------------------------------------------
package pbs_pkg;

    localparam int VALUE_BITS = 24;
    localparam int DT_BITS    = 23;
    localparam int CH_W       = 4;
    localparam int STEP_W     = 16;
    localparam int HR_W       = 16;
    localparam int MET_W      = 40;
    localparam int MIDX_W     = 5;
    localparam int AREA_W     = 64;
    localparam int DUR_W      = 40;
    localparam int PROD_W     = VALUE_BITS + DT_BITS + 1;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int N_PEAK     = 5;
    localparam int N_AREA     = 7;
    localparam int N_ED       = 2;
    localparam int SLOT_W     = 3;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE_THRESH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_EARLY_LIMIT  = 1'b1;
    localparam logic signed [CFG_W-1:0] SLOPE_RESET = 24'sd5120;
    localparam logic [STEP_W-1:0]       LIMIT_RESET = 16'd200;

    // 5000 mmHg in Q8, clamped to the value range
    localparam longint TROUGH_RAW = 64'sd1280000;
    localparam longint VMAX       = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
    localparam logic signed [VALUE_BITS-1:0] TROUGH_INIT =
        VALUE_BITS'((TROUGH_RAW > VMAX) ? VMAX : TROUGH_RAW);

    // channel numbers
    localparam logic [CH_W-1:0] CH_ART   = 4'd0;
    localparam logic [CH_W-1:0] CH_LV    = 4'd1;
    localparam logic [CH_W-1:0] CH_RV    = 4'd2;
    localparam logic [CH_W-1:0] CH_RA    = 4'd3;
    localparam logic [CH_W-1:0] CH_LA    = 4'd4;
    localparam logic [CH_W-1:0] CH_VEN   = 4'd5;
    localparam logic [CH_W-1:0] CH_PA    = 4'd6;
    localparam logic [CH_W-1:0] CH_PV    = 4'd7;
    localparam logic [CH_W-1:0] CH_LVOUT = 4'd8;

    localparam logic [STEP_W-1:0] STEP_NEW_BEAT = 16'd1;

    // metric numbers in report order
    localparam logic [MIDX_W-1:0] M_ABP_SYS  = 5'd0;
    localparam logic [MIDX_W-1:0] M_ABP_MEAN = 5'd1;
    localparam logic [MIDX_W-1:0] M_ABP_DIA  = 5'd2;
    localparam logic [MIDX_W-1:0] M_LVP_SYS  = 5'd3;
    localparam logic [MIDX_W-1:0] M_LVP_ED   = 5'd4;
    localparam logic [MIDX_W-1:0] M_LVP_MIN  = 5'd5;
    localparam logic [MIDX_W-1:0] M_RVP_SYS  = 5'd6;
    localparam logic [MIDX_W-1:0] M_RVP_ED   = 5'd7;
    localparam logic [MIDX_W-1:0] M_RVP_MIN  = 5'd8;
    localparam logic [MIDX_W-1:0] M_RA_MEAN  = 5'd9;
    localparam logic [MIDX_W-1:0] M_LA_MEAN  = 5'd10;
    localparam logic [MIDX_W-1:0] M_VEN_MEAN = 5'd11;
    localparam logic [MIDX_W-1:0] M_PAP_SYS  = 5'd12;
    localparam logic [MIDX_W-1:0] M_PAP_MEAN = 5'd13;
    localparam logic [MIDX_W-1:0] M_PAP_DIA  = 5'd14;
    localparam logic [MIDX_W-1:0] M_SV       = 5'd15;
    localparam logic [MIDX_W-1:0] M_CO       = 5'd16;
    localparam logic [MIDX_W-1:0] M_HR       = 5'd17;
    localparam logic [MIDX_W-1:0] M_PVP_MAX  = 5'd18;
    localparam logic [MIDX_W-1:0] M_PVP_MEAN = 5'd19;
    localparam logic [MIDX_W-1:0] M_PVP_MIN  = 5'd20;

    typedef struct packed {
        logic [CH_W-1:0]              channel;
        logic signed [VALUE_BITS-1:0] sample_value;
        logic signed [VALUE_BITS-1:0] sample_slope;
        logic [DT_BITS-1:0]           step_dt;
        logic [STEP_W-1:0]            step_index;
        logic [HR_W-1:0]              heart_rate;
    } t_item;

    typedef struct packed {
        logic [MIDX_W-1:0]       metric_index;
        logic signed [MET_W-1:0] metric_value;
        logic                    last;
    } t_result;

    typedef struct packed {
        logic  report;
        t_item item;
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
    } t_slot;

    function automatic t_slot peak_slot(input logic [CH_W-1:0] ch);
        t_slot s;
        s = '{en: 1'b1, idx: 3'd0};
        case (ch)
            CH_ART:  s.idx = 3'd0;
            CH_LV:   s.idx = 3'd1;
            CH_RV:   s.idx = 3'd2;
            CH_PA:   s.idx = 3'd3;
            CH_PV:   s.idx = 3'd4;
            default: s.en  = 1'b0;
        endcase
        return s;
    endfunction

    function automatic t_slot area_slot(input logic [CH_W-1:0] ch);
        t_slot s;
        s = '{en: 1'b1, idx: 3'd0};
        case (ch)
            CH_ART:   s.idx = 3'd0;
            CH_RA:    s.idx = 3'd1;
            CH_LA:    s.idx = 3'd2;
            CH_VEN:   s.idx = 3'd3;
            CH_PA:    s.idx = 3'd4;
            CH_PV:    s.idx = 3'd5;
            CH_LVOUT: s.idx = 3'd6;
            default:  s.en  = 1'b0;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/pbs_front.sv
// ----------------------------------------------------------------------------
// pbs_front
// Input side: takes items, drops ignored ones, queues the rest as commands.
// ----------------------------------------------------------------------------
module pbs_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  pbs_pkg::t_item i_item,
    output logic           o_cmd_valid,
    output pbs_pkg::t_cmd  o_cmd,
    input  logic           i_cmd_pop
);
    import pbs_pkg::*;

    localparam int QD = 2;

    t_cmd       r_q [QD];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_acc, w_keep, w_report, w_wr, w_rd;

    always_comb begin
        w_report = (i_item.step_index == STEP_NEW_BEAT) && (i_item.channel == CH_ART);
        // other new-beat items and unused channels change nothing
        w_keep   = (i_item.step_index != STEP_NEW_BEAT || w_report) &&
                   (i_item.channel <= CH_LVOUT);
    end

    assign o_full      = (r_cnt == 2'(QD));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_acc       = i_push && !o_full;
    assign w_wr        = w_acc && w_keep;
    assign w_rd        = i_cmd_pop && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= '{report: w_report, item: i_item};
        end
    end

endmodule

// File: rtl/pbs_div.sv
// ----------------------------------------------------------------------------
// pbs_div
// Rounded signed-by-unsigned divider, one quotient bit per cycle, 40-bit
// saturated result.
// ----------------------------------------------------------------------------
module pbs_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [pbs_pkg::AREA_W-1:0]     i_num,
    input  logic [pbs_pkg::DUR_W-1:0]             i_den,
    output logic                                  o_done,
    output logic signed [pbs_pkg::MET_W-1:0]      o_quot
);
    import pbs_pkg::*;

    localparam int QW = AREA_W + 1;
    localparam int CW = $clog2(QW + 1);

    logic [CW-1:0]      r_cnt;
    logic               r_busy, r_neg;
    logic [DUR_W:0]     r_rem;
    logic [QW-1:0]      r_quo;
    logic [DUR_W-1:0]   r_den;
    logic [AREA_W-1:0]  w_mag;
    logic [DUR_W:0]     w_sh;
    logic               w_ge, w_big;

    assign w_mag = i_num[AREA_W-1] ? (AREA_W'(0) - AREA_W'(i_num)) : AREA_W'(i_num);
    assign w_sh  = {r_rem[DUR_W-1:0], r_quo[QW-1]};
    assign w_ge  = (w_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // bias by half the divisor for round-to-nearest
            r_quo <= {1'b0, w_mag} + QW'(i_den >> 1);
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[AREA_W-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_sh - {1'b0, r_den}) : w_sh;
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign w_big = |r_quo[QW-1:MET_W-1];

    always_comb begin
        if (r_neg) begin
            o_quot = w_big ? {1'b1, {(MET_W-1){1'b0}}}
                           : MET_W'(0) - {1'b0, r_quo[MET_W-2:0]};
        end else begin
            o_quot = w_big ? {1'b0, {(MET_W-1){1'b1}}} : {1'b0, r_quo[MET_W-2:0]};
        end
    end

endmodule

// File: rtl/pbs_back.sv
// ----------------------------------------------------------------------------
// pbs_back
// Execution side: per-beat trackers, accumulate updates and the report
// sequencer that emits the 21 metrics.
// ----------------------------------------------------------------------------
module pbs_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pbs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pbs_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            i_cmd_valid,
    input  pbs_pkg::t_cmd                   i_cmd,
    output logic                            o_cmd_pop,
    input  logic                            i_ofull,
    output logic                            o_opush,
    output pbs_pkg::t_result                o_res
);
    import pbs_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ACC  = 3'd1;
    localparam logic [2:0] ST_MET  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_CO   = 3'd4;
    localparam logic [2:0] ST_PUSH = 3'd5;

    localparam logic [1:0] K_DIRECT = 2'd0;
    localparam logic [1:0] K_DIV    = 2'd1;
    localparam logic [1:0] K_SV     = 2'd2;
    localparam logic [1:0] K_CO     = 2'd3;

    localparam int COP_W = MET_W + HR_W + 1;

    logic signed [CFG_W-1:0]      r_thresh;
    logic [STEP_W-1:0]            r_limit;
    logic signed [VALUE_BITS-1:0] r_peak   [N_PEAK];
    logic signed [VALUE_BITS-1:0] r_trough [N_PEAK];
    logic signed [AREA_W-1:0]     r_area   [N_AREA];
    logic signed [VALUE_BITS-1:0] r_ed     [N_ED];
    logic [DUR_W-1:0]             r_dur;

    logic [2:0]                   r_state;
    logic [MIDX_W-1:0]            r_k;
    t_item                        r_it;
    logic signed [AREA_W-1:0]     r_prod;
    logic signed [MET_W-1:0]      r_mval;
    logic signed [MET_W-1:0]      r_sv;
    logic signed [COP_W-1:0]      r_co;

    logic signed [PROD_W-1:0]     w_prod;
    t_slot                        w_ps, w_as;
    logic signed [AREA_W-1:0]     w_area_cur, w_area_new;
    logic signed [AREA_W:0]       w_sum;
    logic [DUR_W:0]               w_dur_sum;
    logic                         w_ed_hit;
    logic [1:0]                   w_kind;
    logic signed [MET_W-1:0]      w_direct;
    logic signed [AREA_W-1:0]     w_div_num;
    logic                         w_div_start, w_div_done;
    logic signed [MET_W-1:0]      w_div_q;
    logic [AREA_W-1:0]            w_sv_mag;
    logic [AREA_W:0]              w_sv_rnd;
    logic signed [MET_W-1:0]      w_sv;
    logic [COP_W-2:0]             w_co_mag;
    logic [COP_W-1:0]             w_co_rnd;
    logic signed [MET_W-1:0]      w_co;
    logic                         w_last;

    assign w_prod = i_cmd.item.sample_value * $signed({1'b0, i_cmd.item.step_dt});

    // accumulate path
    always_comb begin
        w_ps       = peak_slot(r_it.channel);
        w_as       = area_slot(r_it.channel);
        w_area_cur = r_area[w_as.idx];
        w_sum      = {w_area_cur[AREA_W-1], w_area_cur} + {r_prod[AREA_W-1], r_prod};
        if (w_sum[AREA_W] != w_sum[AREA_W-1]) begin
            w_area_new = w_sum[AREA_W] ? {1'b1, {(AREA_W-1){1'b0}}}
                                       : {1'b0, {(AREA_W-1){1'b1}}};
        end else begin
            w_area_new = w_sum[AREA_W-1:0];
        end
        w_dur_sum = {1'b0, r_dur} + (DUR_W+1)'(r_it.step_dt);
        w_ed_hit  = (r_it.channel == CH_LV || r_it.channel == CH_RV) &&
                    (r_it.step_index < r_limit) &&
                    ((MET_W)'(r_it.sample_slope) < (MET_W)'(r_thresh));
    end

    // stroke volume: area / 2^32, rounded half away from zero
    always_comb begin
        w_sv_mag = r_area[6][AREA_W-1] ? (AREA_W'(0) - AREA_W'(r_area[6]))
                                       : AREA_W'(r_area[6]);
        w_sv_rnd = {1'b0, w_sv_mag} + (AREA_W+1)'(64'h8000_0000);
        w_sv     = r_area[6][AREA_W-1] ? (MET_W'(0) - MET_W'(w_sv_rnd >> 32))
                                       : MET_W'(w_sv_rnd >> 32);
    end

    // cardiac output: sv * hr / 256; |sv * hr| stays far below the 64-bit range
    always_comb begin
        w_co_mag = r_co[COP_W-1] ? (COP_W-1)'(COP_W'(0) - COP_W'(r_co))
                                 : (COP_W-1)'(r_co);
        w_co_rnd = ({1'b0, w_co_mag} + COP_W'(128)) >> 8;
        if (|w_co_rnd[COP_W-1:MET_W-1]) begin
            w_co = r_co[COP_W-1] ? {1'b1, {(MET_W-1){1'b0}}} : {1'b0, {(MET_W-1){1'b1}}};
        end else begin
            w_co = r_co[COP_W-1] ? (MET_W'(0) - MET_W'(w_co_rnd))
                                 : MET_W'(w_co_rnd);
        end
    end

    // metric decode
    always_comb begin
        w_kind    = K_DIRECT;
        w_direct  = '0;
        w_div_num = r_area[0];
        case (r_k)
            M_ABP_SYS:  w_direct = MET_W'(r_peak[0]);
            M_ABP_MEAN: begin w_kind = K_DIV; w_div_num = r_area[0]; end
            M_ABP_DIA:  w_direct = MET_W'(r_trough[0]);
            M_LVP_SYS:  w_direct = MET_W'(r_peak[1]);
            M_LVP_ED:   w_direct = MET_W'(r_ed[0]);
            M_LVP_MIN:  w_direct = MET_W'(r_trough[1]);
            M_RVP_SYS:  w_direct = MET_W'(r_peak[2]);
            M_RVP_ED:   w_direct = MET_W'(r_ed[1]);
            M_RVP_MIN:  w_direct = MET_W'(r_trough[2]);
            M_RA_MEAN:  begin w_kind = K_DIV; w_div_num = r_area[1]; end
            M_LA_MEAN:  begin w_kind = K_DIV; w_div_num = r_area[2]; end
            M_VEN_MEAN: begin w_kind = K_DIV; w_div_num = r_area[3]; end
            M_PAP_SYS:  w_direct = MET_W'(r_peak[3]);
            M_PAP_MEAN: begin w_kind = K_DIV; w_div_num = r_area[4]; end
            M_PAP_DIA:  w_direct = MET_W'(r_trough[3]);
            M_SV:       w_kind = K_SV;
            M_CO:       w_kind = K_CO;
            M_HR:       w_direct = MET_W'({1'b0, r_it.heart_rate});
            M_PVP_MAX:  w_direct = MET_W'(r_peak[4]);
            M_PVP_MEAN: begin w_kind = K_DIV; w_div_num = r_area[5]; end
            M_PVP_MIN:  w_direct = MET_W'(r_trough[4]);
            default:    w_direct = '0;
        endcase
    end

    assign w_div_start = (r_state == ST_MET) && (w_kind == K_DIV) && (r_dur != '0);
    assign o_cmd_pop   = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_opush     = (r_state == ST_PUSH) && !i_ofull;
    assign w_last      = (r_k == M_PVP_MIN);
    assign o_res       = '{metric_index: r_k, metric_value: r_mval, last: w_last};

    pbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_dur),
        .o_done  (w_div_done),
        .o_quot  (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_k      <= '0;
            r_thresh <= SLOPE_RESET;
            r_limit  <= LIMIT_RESET;
            r_dur    <= '0;
            for (int i = 0; i < N_PEAK; i++) begin
                r_peak[i]   <= '0;
                r_trough[i] <= TROUGH_INIT;
            end
            for (int i = 0; i < N_AREA; i++) begin
                r_area[i] <= '0;
            end
            for (int i = 0; i < N_ED; i++) begin
                r_ed[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SLOPE_THRESH: r_thresh <= i_cfg_wdata;
                    REG_EARLY_LIMIT:  r_limit  <= i_cfg_wdata[STEP_W-1:0];
                    default:          r_limit  <= r_limit;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        r_k     <= '0;
                        r_state <= i_cmd.report ? ST_MET : ST_ACC;
                    end
                end
                ST_ACC: begin
                    for (int i = 0; i < N_PEAK; i++) begin
                        if (w_ps.en && w_ps.idx == SLOT_W'(i)) begin
                            if (r_it.sample_value > r_peak[i]) begin
                                r_peak[i] <= r_it.sample_value;
                            end
                            if (r_it.sample_value < r_trough[i]) begin
                                r_trough[i] <= r_it.sample_value;
                            end
                        end
                    end
                    for (int i = 0; i < N_AREA; i++) begin
                        if (w_as.en && w_as.idx == SLOT_W'(i)) begin
                            r_area[i] <= w_area_new;
                        end
                    end
                    if (w_ed_hit) begin
                        r_ed[r_it.channel == CH_RV] <= r_it.sample_value;
                    end
                    if (r_it.channel == CH_ART) begin
                        r_dur <= w_dur_sum[DUR_W] ? {DUR_W{1'b1}} : w_dur_sum[DUR_W-1:0];
                    end
                    r_state <= ST_IDLE;
                end
                ST_MET: begin
                    case (w_kind)
                        K_DIV:   r_state <= (r_dur != '0) ? ST_DIV : ST_PUSH;
                        K_CO:    r_state <= ST_CO;
                        default: r_state <= ST_PUSH;
                    endcase
                end
                ST_DIV: begin
                    if (w_div_done) begin
                        r_state <= ST_PUSH;
                    end
                end
                ST_CO: begin
                    r_state <= ST_PUSH;
                end
                ST_PUSH: begin
                    if (!i_ofull) begin
                        if (w_last) begin
                            r_state <= ST_IDLE;
                            r_dur   <= '0;
                            for (int i = 0; i < N_PEAK; i++) begin
                                r_peak[i]   <= '0;
                                r_trough[i] <= TROUGH_INIT;
                            end
                            for (int i = 0; i < N_AREA; i++) begin
                                r_area[i] <= '0;
                            end
                            for (int i = 0; i < N_ED; i++) begin
                                r_ed[i] <= '0;
                            end
                        end else begin
                            r_k     <= r_k + MIDX_W'(1);
                            r_state <= ST_MET;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_cmd_valid) begin
            r_it   <= i_cmd.item;
            r_prod <= AREA_W'(w_prod);
        end
        if (r_state == ST_MET) begin
            case (w_kind)
                K_DIRECT: r_mval <= w_direct;
                K_DIV:    r_mval <= '0;
                K_SV: begin
                    r_mval <= w_sv;
                    r_sv   <= w_sv;
                end
                K_CO:     r_co <= r_sv * $signed({1'b0, r_it.heart_rate});
                default:  r_mval <= '0;
            endcase
        end
        if (r_state == ST_DIV && w_div_done) begin
            r_mval <= w_div_q;
        end
        if (r_state == ST_CO) begin
            r_mval <= w_co;
        end
    end

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_k <= M_PVP_MIN)
        else $error("metric counter out of range");

    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_state == ST_ACC || r_state == ST_MET))
        else $error("command popped without being executed");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_opush && w_last) |=> (r_state == ST_IDLE && r_dur == '0))
        else $error("report end did not clear trackers");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_opush && !w_last) |=> (r_k == $past(r_k) + MIDX_W'(1)))
        else $error("metric skipped or repeated");

endmodule

// File: rtl/pbs_outq.sv
// ----------------------------------------------------------------------------
// pbs_outq
// Four-entry result queue between the report sequencer and the output port.
// ----------------------------------------------------------------------------
module pbs_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pbs_pkg::t_result i_res,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output pbs_pkg::t_result o_res
);
    import pbs_pkg::*;

    localparam int QD = 4;

    t_result    r_q [QD];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_wr, w_rd;

    assign o_full  = (r_cnt == 3'(QD));
    assign o_empty = (r_cnt == 3'd0);
    assign o_res   = r_q[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= r_wp + 2'd1;
            end
            if (w_rd) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + 3'(w_wr) - 3'(w_rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

// File: rtl/per_beat_pressure_statistics.sv
// Accumulating item: it passes through the command queue, then the execution
//   stage, where the trackers update; a new command is taken only when idle.
// Report item: 21 metrics, six of them divisions on the shared bit-serial
//   divider; the other metrics are read directly or computed without it.
// Reset (synchronous, active low) clears trackers and queues and restores config to its reset values at once.
// ----------------------------------------------------------------------------
// per_beat_pressure_statistics
// Per-beat peak, minimum, mean and end-diastolic pressure statistics, plus SV, CO and HR.
// ----------------------------------------------------------------------------
module per_beat_pressure_statistics (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  pbs_pkg::t_item                i_item,
    output logic                          o_empty,
    input  logic                          i_pop,
    output pbs_pkg::t_result              o_result,
    input  logic                          i_cfg_we,
    input  logic [pbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pbs_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import pbs_pkg::*;

    logic    w_cmd_valid, w_cmd_pop, w_ofull, w_opush;
    t_cmd    w_cmd;
    t_result w_res;

    pbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_item      (i_item),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    pbs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .i_ofull     (w_ofull),
        .o_opush     (w_opush),
        .o_res       (w_res)
    );

    pbs_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_opush),
        .i_res   (w_res),
        .o_full  (w_ofull),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_res   (o_result)
    );

endmodule
